// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever ante holds, cons must hold in the same cycle.
`define SMX_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

// Whenever ante holds, cons must hold in the following cycle.
`define SMX_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define SMX_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SMX_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/smx_pkg.sv -----
// ----------------------------------------------------------------------------
// Softmax package
// Types, constants and tables shared by the softmax controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smx_pkg;

	// Field widths.
	localparam int SCORE_W = 16;
	localparam int PROB_W  = 16;
	localparam int EXP_W   = 32;
	localparam int SUM_W   = 40;
	localparam int DEN_W   = 41;
	localparam int DIV_QW  = 17;
	localparam int DIV_NW  = DEN_W + DIV_QW - 1;
	localparam int CFG_IDX_W = 1;

	// ln 2 in Q.28 and the reciprocal of ln 2 scaled by 2^14.
	localparam logic [27:0] LN2_Q28 = 28'd186065280;
	localparam logic [15:0] K_RECIP = 16'd23637;
	localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_MARGIN  = 1'b0,
		REG_HIGH_MARGIN = 1'b1
	} cfg_reg_e;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exp_start;
		logic store_exp;
		logic set_drop;
		logic clear_run;
		logic idx_clr;
		logic idx_inc;
		logic total_clr;
		logic rd_exp;
		logic div1_start;
		logic wr_prob;
		logic rd_prob;
		logic mul_prob;
		logic div2_start;
		logic out_load;
	} smx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic exp_done;
		logic div_done;
		logic div_busy;
		logic store_full;
		logic count_zero;
		logic idx_last;
		logic rescale;
		logic out_free;
	} smx_sts_t;

	// Ceiling of 2^32 / n for the Taylor term divisors 1 to 12.
	function automatic logic [32:0] recip_n(input logic [3:0] n);
		logic [32:0] r;
		case (n)
			4'd1:    r = 33'h1_0000_0000;
			4'd2:    r = 33'h0_8000_0000;
			4'd3:    r = 33'h0_5555_5556;
			4'd4:    r = 33'h0_4000_0000;
			4'd5:    r = 33'h0_3333_3334;
			4'd6:    r = 33'h0_2AAA_AAAB;
			4'd7:    r = 33'h0_2492_4925;
			4'd8:    r = 33'h0_2000_0000;
			4'd9:    r = 33'h0_1C71_C71D;
			4'd10:   r = 33'h0_1999_999A;
			4'd11:   r = 33'h0_1745_D175;
			4'd12:   r = 33'h0_1555_5556;
			default: r = 33'h1_0000_0000;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/smx_div.sv -----
// ----------------------------------------------------------------------------
// Softmax divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_div import smx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DEN_W-1:0]  den,
	output logic              busy,
	output logic              done,
	output logic [DIV_QW-1:0] quot
);

	logic [DIV_NW-1:0] rem_q;
	logic [DIV_NW-1:0] dsh_q;
	logic [DIV_QW-1:0] quot_q;
	logic [4:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	// Trial subtraction of the shifted divisor.
	assign ge = (rem_q >= dsh_q);

	// Control: busy for one cycle per quotient bit, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'(DIV_QW - 1);
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end

	// Datapath: remainder, shifted divisor and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= {den, {(DIV_QW-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			quot_q <= {quot_q[DIV_QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/smx_exp.sv -----
// ----------------------------------------------------------------------------
// Softmax exponential unit
// Range reduction by ln 2, twelve Taylor terms and a final binary shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_exp import smx_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SCORE_W-1:0] score,
	output logic                      done,
	output logic [EXP_W-1:0]          value
);

	typedef enum logic [2:0] {
		E_IDLE, E_KEST, E_RED, E_MUL, E_RCP, E_ACC, E_SHIFT
	} exp_state_t;

	exp_state_t                state_q;
	logic signed [SCORE_W-1:0] score_q;
	logic signed [32:0]        m_q;
	logic signed [5:0]         k_q;
	logic signed [33:0]        kl_q;
	logic [27:0]               r_q;
	logic [28:0]               term_q;
	logic [29:0]               acc_q;
	logic [28:0]               v_q;
	logic [56:0]               prod_q;
	logic [61:0]               mq_q;
	logic [3:0]                n_q;
	logic [EXP_W-1:0]          value_q;
	logic                      done_q;

	logic signed [5:0]  k0;
	logic signed [34:0] x35;
	logic signed [34:0] r0;
	logic signed [34:0] ln2_35;
	logic [29:0]        qe;
	logic [33:0]        chk;
	logic [29:0]        qc;
	logic signed [6:0]  sh;
	logic [4:0]         rs;
	logic [30:0]        rnd;
	logic [30:0]        rsum;
	logic [31:0]        shifted;

	// Reduction and term arithmetic.
	always_comb begin
		k0     = m_q[31:26];
		x35    = {{3{score_q[SCORE_W-1]}}, score_q, 16'b0};
		ln2_35 = {7'b0, LN2_Q28};
		r0     = x35 - {kl_q[33], kl_q};
		qe     = mq_q[61:32];
		chk    = qe * n_q;
		qc     = (chk > {5'b0, v_q}) ? (qe - 30'd1) : qe;
		sh     = {k_q[5], k_q} - 7'sd8;
		rs     = 5'(-sh);
		rnd    = 31'd1 << (rs - 5'd1);
		rsum   = {1'b0, acc_q} + rnd;
		if (sh[6])
			shifted = {1'b0, 31'(rsum >> rs)};
		else
			shifted = {2'b0, acc_q} << sh[1:0];
	end

	// Sequencer and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (start) begin
						score_q <= score;
						m_q     <= score * $signed({1'b0, K_RECIP});
						state_q <= E_KEST;
					end
				end
				E_KEST: begin
					k_q     <= k0;
					kl_q    <= k0 * $signed({1'b0, LN2_Q28});
					state_q <= E_RED;
				end
				E_RED: begin
					// Correct the estimated exponent by at most one step.
					if (r0[34]) begin
						k_q <= k_q - 6'sd1;
						r_q <= 28'(r0 + ln2_35);
					end else if (r0 >= ln2_35) begin
						k_q <= k_q + 6'sd1;
						r_q <= 28'(r0 - ln2_35);
					end else begin
						r_q <= r0[27:0];
					end
					term_q  <= 29'h1000_0000;
					acc_q   <= 30'h1000_0000;
					n_q     <= 4'd1;
					state_q <= E_MUL;
				end
				E_MUL: begin
					prod_q  <= term_q * r_q;
					state_q <= E_RCP;
				end
				E_RCP: begin
					v_q     <= prod_q[56:28];
					mq_q    <= prod_q[56:28] * recip_n(n_q);
					state_q <= E_ACC;
				end
				E_ACC: begin
					term_q <= qc[28:0];
					acc_q  <= acc_q + qc;
					if (n_q == TAYLOR_TERMS) begin
						state_q <= E_SHIFT;
					end else begin
						n_q     <= n_q + 4'd1;
						state_q <= E_MUL;
					end
				end
				E_SHIFT: begin
					value_q <= shifted;
					done_q  <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

// ----- hdl/smx_dp.sv -----
// ----------------------------------------------------------------------------
// Softmax datapath
// Exponential store, running sums, divider, clamp and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_dp import smx_pkg::*; #(
	parameter int MAX_CATEGORIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smx_cmd_t             cmd,
	output smx_sts_t             sts,
	input  logic [SCORE_W-1:0]   in_score,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PROB_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PROB_W-1:0]    out_prob,
	output logic                 out_last,
	output logic                 out_ovf
);

	localparam int CW = $clog2(MAX_CATEGORIES + 1);
	localparam int AW = $clog2(MAX_CATEGORIES);
	localparam int TW = PROB_W + CW;

	logic [EXP_W-1:0]  exp_mem [MAX_CATEGORIES];
	logic [PROB_W-1:0] prob_mem [MAX_CATEGORIES];

	logic [PROB_W-1:0] low_q;
	logic [PROB_W-1:0] high_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              drop_q;
	logic [TW-1:0]     total_q;
	logic [EXP_W-1:0]  rd_exp_q;
	logic [PROB_W-1:0] rd_prob_q;
	logic [32:0]       prod_q;
	logic              out_valid_q;
	logic [PROB_W-1:0] out_prob_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              exp_done;
	logic [EXP_W-1:0]  exp_value;
	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_busy;
	logic              div_done;
	logic [DIV_QW-1:0] div_quot;

	logic [16:0]       upper;
	logic [DEN_W-1:0]  den_d;
	logic [PROB_W-1:0] q_sat;
	logic [PROB_W-1:0] p_hi;
	logic [PROB_W-1:0] p_clamp;
	logic              idx_last;

	smx_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exp_start),
		.score  (in_score),
		.done   (exp_done),
		.value  (exp_value)
	);

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Divider operands, saturation and clamp.
	always_comb begin
		upper     = 17'h1_0000 - {1'b0, high_q};
		den_d     = {1'b0, sum_q} + 41'h10_0000;
		div_start = cmd.div1_start | cmd.div2_start;
		if (cmd.div1_start) begin
			div_num = DIV_NW'({rd_exp_q, 16'b0}) + DIV_NW'(den_d >> 1);
			div_den = den_d;
		end else begin
			div_num = DIV_NW'(prod_q) + DIV_NW'(total_q >> 1);
			div_den = DEN_W'(total_q);
		end
		q_sat   = div_quot[DIV_QW-1] ? {PROB_W{1'b1}} : div_quot[PROB_W-1:0];
		p_hi    = ({1'b0, q_sat} > upper) ? upper[PROB_W-1:0] : q_sat;
		p_clamp = (p_hi < low_q) ? low_q : p_hi;
		idx_last = (idx_q + CW'(1)) == count_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 16'd1;
			high_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_LOW_MARGIN:  low_q  <= cfg_data;
				REG_HIGH_MARGIN: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Run state: sum, count, drop flag, index and clamped total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clear_run) begin
				sum_q   <= '0;
				count_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				if (cmd.store_exp) begin
					sum_q   <= sum_q + SUM_W'(exp_value);
					count_q <= count_q + CW'(1);
				end
				if (cmd.set_drop)
					drop_q <= 1'b1;
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + CW'(1);
			if (cmd.total_clr)
				total_q <= '0;
			else if (cmd.wr_prob)
				total_q <= total_q + TW'(p_clamp);
		end
	end

	// Exponential and probability stores with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.store_exp)
			exp_mem[count_q[AW-1:0]] <= exp_value;
		if (cmd.rd_exp)
			rd_exp_q <= exp_mem[idx_q[AW-1:0]];
		if (cmd.wr_prob)
			prob_mem[idx_q[AW-1:0]] <= p_clamp;
		if (cmd.rd_prob)
			rd_prob_q <= prob_mem[idx_q[AW-1:0]];
		if (cmd.mul_prob)
			prod_q <= rd_prob_q * upper;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_prob_q <= sts.rescale ? q_sat : rd_prob_q;
			out_last_q <= idx_last;
			out_ovf_q  <= drop_q;
		end
	end

	always_comb begin
		sts.exp_done   = exp_done;
		sts.div_done   = div_done;
		sts.div_busy   = div_busy;
		sts.store_full = (count_q == CW'(MAX_CATEGORIES));
		sts.count_zero = (count_q == '0);
		sts.idx_last   = idx_last;
		sts.rescale    = (TW'(total_q) > TW'(upper));
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_prob  = out_prob_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

// ----- hdl/smx_ctrl.sv -----
// ----------------------------------------------------------------------------
// Softmax controller
// Sequences loading, the division pass and the rescale and emission pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_ctrl import smx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  smx_sts_t sts,
	output smx_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXP, ST_FIN,
		ST_P1_RD, ST_P1_DIV, ST_P1_WAIT, ST_P1_WR,
		ST_P2_RD, ST_P2_MUL, ST_P2_DIV, ST_P2_WAIT, ST_P2_OUT
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        last_q;

	// Command decode and next state.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!sts.store_full) begin
						cmd.exp_start = 1'b1;
						state_d = ST_EXP;
					end else begin
						cmd.set_drop = 1'b1;
						if (in_last)
							state_d = ST_FIN;
					end
				end
			end
			ST_EXP: begin
				if (sts.exp_done) begin
					cmd.store_exp = 1'b1;
					state_d = last_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				if (sts.count_zero) begin
					cmd.clear_run = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.idx_clr   = 1'b1;
					cmd.total_clr = 1'b1;
					state_d = ST_P1_RD;
				end
			end
			ST_P1_RD: begin
				cmd.rd_exp = 1'b1;
				state_d = ST_P1_DIV;
			end
			ST_P1_DIV: begin
				cmd.div1_start = 1'b1;
				state_d = ST_P1_WAIT;
			end
			ST_P1_WAIT: begin
				if (sts.div_done)
					state_d = ST_P1_WR;
			end
			ST_P1_WR: begin
				cmd.wr_prob = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d = ST_P2_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_P1_RD;
				end
			end
			ST_P2_RD: begin
				cmd.rd_prob = 1'b1;
				state_d = ST_P2_MUL;
			end
			ST_P2_MUL: begin
				cmd.mul_prob = 1'b1;
				state_d = sts.rescale ? ST_P2_DIV : ST_P2_OUT;
			end
			ST_P2_DIV: begin
				cmd.div2_start = 1'b1;
				state_d = ST_P2_WAIT;
			end
			ST_P2_WAIT: begin
				if (sts.div_done)
					state_d = ST_P2_OUT;
			end
			ST_P2_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.clear_run = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = ST_P2_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and the latched last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid)
				last_q <= in_last;
		end
	end

endmodule

// ----- hdl/softmax_reference_clamped.sv -----
// ----------------------------------------------------------------------------
// Reference-category softmax with clamping
// Stores exp(score) per item and emits clamped, renormalised probabilities.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata score, s_tlast final_score
//  m_      | out       | m_tvalid/m_tready  | m_tdata probability, m_tlast, m_tuser
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each stored score passes through the iterative exponential unit (twelve
// Taylor terms, each through multiply, reciprocal and accumulate states,
// plus reduction and shift). After the last item, each result goes through
// the shared divider in the division pass and again in the rescale pass if rescaling is needed.
// No clearing pass is needed after reset; configuration is always accepted.
// A stalled output holds its item; the final result may wait while new
// items are loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module softmax_reference_clamped import smx_pkg::*; #(
	parameter int MAX_CATEGORIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] score
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [15:0] probability
	output logic                 m_tlast,
	output logic                 m_tuser,   // [0] overflowed
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	smx_cmd_t cmd;
	smx_sts_t sts;

	assign cfg_ready = 1'b1;

	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smx_dp #(
		.MAX_CATEGORIES (MAX_CATEGORIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_score  (s_tdata),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_prob  (m_tdata),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser)
	);

	// The output register is only reloaded when it is free.
	`SMX_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, sts.out_free)
	// No exponential is started once the store is full.
	`SMX_ASSERT_IMP(a_exp_room, clk, arst_n, cmd.exp_start, !sts.store_full)
	// The divider is never restarted while a division is in progress.
	`SMX_ASSERT_IMP(a_div_idle, clk, arst_n, cmd.div1_start || cmd.div2_start, !sts.div_busy)
	// A started division keeps the divider busy in the next cycle.
	`SMX_ASSERT_NXT(a_div_runs, clk, arst_n, cmd.div1_start || cmd.div2_start, sts.div_busy)

endmodule

// ----- bench/softmax_reference_clamped_checker.sv -----
// ----------------------------------------------------------------------------
// Softmax result checker
// Watches the score, probability and register channels of the clamped
// softmax. It keeps its own copy of the stored exponentials and the margins,
// works out every probability of a vector when its last score is taken, and
// compares each probability that leaves the block with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module softmax_reference_clamped_checker import smx_pkg::*; #(
	parameter int MAX_CATEGORIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,
	input  logic                 m_tlast,
	input  logic                 m_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   checked,
	output int                   overflow_runs
);

	typedef struct {
		logic [15:0] probability;
		logic        last;
		logic        overflowed;
	} prob_item_t;

	prob_item_t  due_probs[$];
	logic [15:0] low_margin_q;
	logic [15:0] high_margin_q;
	logic [31:0] exp_vals[MAX_CATEGORIES];
	logic [39:0] exp_total;
	int          stored;
	logic        dropped;

	// Exponential of a Q4.12 score in Q12.20, by range reduction and a Taylor sum.
	function automatic logic [31:0] exp_q20(input logic signed [15:0] s);
		longint     x;
		longint     k;
		longint     shift;
		longint unsigned r;
		longint unsigned term;
		longint unsigned acc;
		x = longint'(s) * 65536;
		k = x / longint'(LN2_Q28);
		if (k * longint'(LN2_Q28) > x)
			k = k - 1;
		r = longint'(x - k * longint'(LN2_Q28));
		term = 64'd1 << 28;
		acc = term;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * r) >> 28) / longint'(n);
			acc += term;
		end
		shift = k - 8;
		if (shift >= 0)
			acc = acc << shift;
		else
			acc = (acc + (64'd1 << (-shift - 1))) >> (-shift);
		return acc[31:0];
	endfunction

	// Turn the stored exponentials into clamped, rescaled probabilities.
	task automatic emit_vector();
		longint unsigned den;
		longint unsigned upper;
		longint unsigned total;
		longint unsigned p;
		longint unsigned probs[MAX_CATEGORIES];
		prob_item_t      it;
		den = (64'd1 << 20) + exp_total;
		upper = 65536 - high_margin_q;
		total = 0;
		for (int j = 0; j < stored; j++) begin
			p = (longint'(exp_vals[j]) * 65536 + den / 2) / den;
			if (p > 65535)
				p = 65535;
			if (p > upper)
				p = upper;
			if (p < low_margin_q)
				p = low_margin_q;
			probs[j] = p;
			total += p;
		end
		if (total > upper) begin
			for (int j = 0; j < stored; j++)
				probs[j] = (probs[j] * upper + total / 2) / total;
		end
		for (int j = 0; j < stored; j++) begin
			it.probability = (probs[j] > 65535) ? 16'hFFFF : probs[j][15:0];
			it.last = (j + 1 == stored);
			it.overflowed = dropped;
			due_probs.push_back(it);
		end
		if (dropped)
			overflow_runs++;
		exp_total = '0;
		stored = 0;
		dropped = 1'b0;
	endtask

	// Register writes, accepted scores and emitted probabilities.
	always @(posedge clk or negedge arst_n) begin
		prob_item_t want;
		if (!arst_n) begin
			low_margin_q = 16'd1;
			high_margin_q = 16'd1;
			exp_total = '0;
			stored = 0;
			dropped = 1'b0;
			due_probs.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LOW_MARGIN)
					low_margin_q = cfg_data;
				else if (cfg_index == REG_HIGH_MARGIN)
					high_margin_q = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (stored < MAX_CATEGORIES) begin
					exp_vals[stored] = exp_q20(s_tdata);
					exp_total = exp_total + exp_vals[stored];
					stored++;
				end else begin
					dropped = 1'b1;
				end
				if (s_tlast)
					emit_vector();
			end
			if (m_tvalid && m_tready) begin
				if (due_probs.size() == 0) begin
					$error("probability %0d emitted with nothing due", m_tdata);
					errors++;
				end else begin
					want = due_probs.pop_front();
					checked++;
					if (m_tdata !== want.probability) begin
						$error("probability: expected %0d, got %0d", want.probability, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("final_probability: expected %0b, got %0b", want.last, m_tlast);
						errors++;
					end
					if (m_tuser !== want.overflowed) begin
						$error("overflowed: expected %0b, got %0b", want.overflowed, m_tuser);
						errors++;
					end
				end
			end
		end
		pending = due_probs.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		overflow_runs = 0;
	end

endmodule

// ----- bench/tb_softmax_reference_clamped.sv -----
// ----------------------------------------------------------------------------
// Clamped softmax testbench
// Feeds vectors of scores, from single scores to runs past the store's
// capacity, under several margin settings, with random gaps and output
// stalls; the checker beside the block judges every probability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_softmax_reference_clamped;
	import smx_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;   // [15:0] score
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;        // [15:0] probability
	logic                 m_tlast;
	logic                 m_tuser;        // [0] overflowed
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	int errors;
	int pending;
	int checked;
	int overflow_runs;
	int scores_sent = 0;
	bit calm = 1'b0;
	bit hold_output = 1'b0;

	always #5 clk = ~clk;

	softmax_reference_clamped u_dut (.*);

	softmax_reference_clamped_checker u_check (.*);

	// Output side: random stalls, a long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_output = 1'b0;
			end
			m_tready <= calm || ($urandom_range(99) >= 34);
		end
	end

	// Offer one score and wait until it is taken.
	task automatic send_score(input logic [15:0] s, input logic last);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(4, 1);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		scores_sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// A vector of given length; full_range picks full-range or moderate scores.
	task automatic send_vector(input int len, input bit full_range);
		logic [15:0] s;
		for (int i = 0; i < len; i++) begin
			s = full_range ? 16'($urandom) : 16'($urandom_range(24576) - 12288);
			send_score(s, i == len - 1);
		end
	endtask

	// Wait for every due probability, then let the block settle.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_margins(input logic [15:0] lo, input logic [15:0] hi);
		drain();
		write_reg(REG_LOW_MARGIN, lo);
		write_reg(REG_HIGH_MARGIN, hi);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, single scores, full store and overflow.
		send_score(16'h7FFF, 1'b1);
		send_score(16'h8000, 1'b1);
		send_score(16'h0000, 1'b1);
		send_score(16'h8000, 1'b0);
		send_score(16'h7FFF, 1'b1);
		send_vector(16, 1'b0);
		send_vector(18, 1'b0);
		set_margins(16'd0, 16'd0);
		send_score(16'h7FFF, 1'b1);
		send_score(16'h8000, 1'b1);
		set_margins(16'hFFFF, 16'hFFFF);
		send_vector(3, 1'b1);
		set_margins(16'd6000, 16'd100);
		send_vector(14, 1'b0);

		// Random vectors under changing margins.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_margins(16'd1, 16'd1);
				1: set_margins(16'($urandom_range(3000)), 16'($urandom_range(3000)));
				2: set_margins(16'($urandom), 16'($urandom));
				3: set_margins(16'd0, 16'd65535);
				default: set_margins(16'($urandom_range(8000)), 16'($urandom_range(200)));
			endcase
			calm = (phase == 2);
			if (phase == 3)
				hold_output = 1'b1;
			while (scores_sent < 58 + 26 * (phase + 1))
				send_vector(($urandom_range(9) == 0) ? $urandom_range(20, 17)
					: $urandom_range(16, 1), $urandom_range(3) == 0);
		end
		calm = 1'b0;
		drain();

		$display("Checked %0d probabilities from %0d scores; %0d vectors overflowed.",
			checked, scores_sent, overflow_runs);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
